>>> rtl/fau_pkg.sv
// Package for the fraction arithmetic unit.
// Holds operation, compare and status codes and the result item layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fau_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] ord_t;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_CMP = 3'd4;

  localparam ord_t ORD_LESS    = 2'd0;
  localparam ord_t ORD_EQUAL   = 2'd1;
  localparam ord_t ORD_GREATER = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam int REQ_W     = 3;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int ORD_W     = 2;
  // res_num, res_den, order, is_negative, padded to whole bytes
  localparam int OUT_TW    = ((RES_NUM_W + RES_DEN_W + ORD_W + 1 + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> rtl/fraction_arithmetic_unit.sv
// Fraction arithmetic unit: add, subtract, multiply, divide and compare of two
// signed fractions with GCD reduction. Uses fau_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One item at a time. After an item is taken, in_tready stays low until the
// result is handed to the output register. A bad request (zero input
// denominator, unknown operation) goes straight to the result; compares, and
// arithmetic that ends in a zero numerator or a zero result denominator, skip
// the GCD loop and the divisions. Otherwise add, subtract, multiply and divide
// run three passes through one shared OPERAND_WIDTH-bit multiplier, a binary
// GCD loop of one shift or subtract-and-shift step per cycle (at most about
// 4*OPERAND_WIDTH steps, data dependent), then two restoring divisions on one
// shared divider. The output register lets the next item enter while a
// finished result waits to be taken.
module fraction_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero padded to bytes
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]    in_tdata,
  // req_type
  input  wire logic [fau_pkg::REQ_W-1:0]               in_tuser,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  // res_num, res_den, order, is_negative from bit 0 up, zero padded to bytes
  output logic [fau_pkg::OUT_TW-1:0]                   out_tdata,
  // status
  output logic                                         out_tuser
);
  import fau_pkg::*;

  localparam int W   = OPERAND_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CW  = $clog2(PW);
  localparam int XW  = (PW > RES_NUM_W) ? PW : RES_NUM_W;
  localparam int DXW = (PW > RES_DEN_W) ? PW : RES_DEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // control
  logic [2:0]    st_r, st_nxt;
  logic [1:0]    ms_r, ms_nxt;
  logic [CW-1:0] dc_r, dc_nxt;
  logic          ov_r, ov_nxt;

  // item and working data
  op_t           op_r, op_nxt;
  logic [3:0]    sg_r, sg_nxt;     // signs of a_num, a_den, b_num, b_den
  logic [W-1:0]  an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [PW-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [PW-1:0] x_r, x_nxt, y_r, y_nxt, nm_r, nm_nxt, dn_r, dn_nxt;
  logic [PW:0]   rem_r, rem_nxt;
  logic [PW-1:0] quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  ord_t          ord_r, ord_nxt;
  logic          sts_r, sts_nxt;

  // output register
  logic [RES_NUM_W-1:0] on_r, on_nxt;
  logic [RES_DEN_W-1:0] od_r, od_nxt;
  ord_t                 oo_r, oo_nxt;
  logic                 og_r, og_nxt, os_r, os_nxt;

  // combinational helpers
  logic [W-1:0]  f_an, f_ad, f_bn, f_bd;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          s_an, s_ad, s_bn, s_bd, s_bne;
  logic          t0, t1, dsg, xn, yn;
  logic          ge01;
  logic [PW-1:0] sum01, dif01, numc;
  logic          numc_s;
  ord_t          cmp_ord;
  logic          gxy;
  logic [PW-1:0] g_big, g_sml, g_dif;
  logic [PW:0]   dv_sh;
  logic          dv_ge;
  logic [PW:0]   dv_rem;
  logic [PW-1:0] dv_quo;
  logic [XW-1:0] fx_num, fx_sgn;
  logic [DXW-1:0] fx_den;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  always_comb begin
    f_an = in_tdata[W-1:0];
    f_ad = in_tdata[2*W-1:W];
    f_bn = in_tdata[3*W-1:2*W];
    f_bd = in_tdata[4*W-1:3*W];
  end

  // shared multiplier
  always_comb begin
    case (ms_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // combine products: signed add, compare, sign of result
  always_comb begin
    s_an   = sg_r[0];
    s_ad   = sg_r[1];
    s_bn   = sg_r[2];
    s_bd   = sg_r[3];
    s_bne  = s_bn ^ (op_r == OP_SUB);
    t0     = s_an ^ ((op_r == OP_MUL) ? s_bn : s_bd);
    t1     = s_ad ^ s_bne;
    dsg    = s_ad ^ ((op_r == OP_DIV) ? s_bn : s_bd);
    ge01   = p0_r >= p1_r;
    sum01  = p0_r + p1_r;
    dif01  = ge01 ? (p0_r - p1_r) : (p1_r - p0_r);
    if (op_r == OP_ADD || op_r == OP_SUB) begin
      if (t0 == t1) begin
        numc   = sum01;
        numc_s = t0;
      end else begin
        numc   = dif01;
        numc_s = ge01 ? t0 : t1;
      end
    end else begin
      numc   = p0_r;
      numc_s = t0;
    end
    xn = (p0_r != '0) && (s_an ^ s_ad);
    yn = (p1_r != '0) && (s_bn ^ s_bd);
    if (xn != yn) begin
      cmp_ord = xn ? ORD_LESS : ORD_GREATER;
    end else if (p0_r == p1_r) begin
      cmp_ord = ORD_EQUAL;
    end else if (!ge01) begin
      cmp_ord = xn ? ORD_GREATER : ORD_LESS;
    end else begin
      cmp_ord = xn ? ORD_LESS : ORD_GREATER;
    end
  end

  // binary GCD step and restoring divider step
  always_comb begin
    gxy    = x_r >= y_r;
    g_big  = gxy ? x_r : y_r;
    g_sml  = gxy ? y_r : x_r;
    g_dif  = g_big - g_sml;
    dv_sh  = {rem_r[PW-1:0], quo_r[PW-1]};
    dv_ge  = dv_sh >= {1'b0, x_r};
    dv_rem = dv_ge ? (dv_sh - {1'b0, x_r}) : dv_sh;
    dv_quo = {quo_r[PW-2:0], dv_ge};
  end

  // format the staged result
  always_comb begin
    fx_num = XW'(nm_r);
    fx_sgn = neg_r ? (~fx_num + XW'(1)) : fx_num;
    fx_den = DXW'(dn_r);
  end

  always_comb begin
    st_nxt  = st_r;
    ms_nxt  = ms_r;
    dc_nxt  = dc_r;
    ov_nxt  = ov_r;
    op_nxt  = op_r;
    sg_nxt  = sg_r;
    an_nxt  = an_r;
    ad_nxt  = ad_r;
    bn_nxt  = bn_r;
    bd_nxt  = bd_r;
    p0_nxt  = p0_r;
    p1_nxt  = p1_r;
    p2_nxt  = p2_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    nm_nxt  = nm_r;
    dn_nxt  = dn_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    neg_nxt = neg_r;
    ord_nxt = ord_r;
    sts_nxt = sts_r;
    on_nxt  = on_r;
    od_nxt  = od_r;
    oo_nxt  = oo_r;
    og_nxt  = og_r;
    os_nxt  = os_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          sg_nxt  = {f_bd[W-1], f_bn[W-1], f_ad[W-1], f_an[W-1]};
          an_nxt  = mag_of(f_an);
          ad_nxt  = mag_of(f_ad);
          bn_nxt  = mag_of(f_bn);
          bd_nxt  = mag_of(f_bd);
          ms_nxt  = 2'd0;
          nm_nxt  = '0;
          dn_nxt  = '0;
          neg_nxt = 1'b0;
          ord_nxt = ORD_LESS;
          sts_nxt = ST_OK;
          // drop straight to the result on a bad request
          if (in_tuser > OP_CMP || f_ad == '0 || f_bd == '0) begin
            sts_nxt = ST_ERR;
            st_nxt  = S_DONE;
          end else begin
            st_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        case (ms_r)
          2'd0:    p0_nxt = prod;
          2'd1:    p1_nxt = prod;
          default: p2_nxt = prod;
        endcase
        ms_nxt = ms_r + 2'd1;
        if (ms_r == 2'd2) begin
          st_nxt = S_COMB;
        end
      end
      S_COMB: begin
        if (op_r == OP_CMP) begin
          ord_nxt = cmp_ord;
          st_nxt  = S_DONE;
        end else if (p2_r == '0) begin
          sts_nxt = ST_ERR;
          st_nxt  = S_DONE;
        end else if (numc == '0) begin
          dn_nxt  = PW'(1);
          st_nxt  = S_DONE;
        end else begin
          x_nxt   = numc;
          y_nxt   = p2_r;
          nm_nxt  = numc;
          dn_nxt  = p2_r;
          neg_nxt = numc_s ^ dsg;
          st_nxt  = S_GCD;
        end
      end
      S_GCD: begin
        if (x_r == y_r) begin
          rem_nxt = '0;
          quo_nxt = nm_r;
          dc_nxt  = '0;
          st_nxt  = S_DIVN;
        end else if (!x_r[0] && !y_r[0]) begin
          // common factor of two: strip it from the saved values too
          x_nxt  = x_r >> 1;
          y_nxt  = y_r >> 1;
          nm_nxt = nm_r >> 1;
          dn_nxt = dn_r >> 1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (gxy) begin
          x_nxt = g_dif >> 1;
        end else begin
          y_nxt = g_dif >> 1;
        end
      end
      S_DIVN: begin
        rem_nxt = dv_rem;
        quo_nxt = dv_quo;
        dc_nxt  = dc_r + CW'(1);
        if (dc_r == CW'(PW - 1)) begin
          nm_nxt  = dv_quo;
          rem_nxt = '0;
          quo_nxt = dn_r;
          dc_nxt  = '0;
          st_nxt  = S_DIVD;
        end
      end
      S_DIVD: begin
        rem_nxt = dv_rem;
        quo_nxt = dv_quo;
        dc_nxt  = dc_r + CW'(1);
        if (dc_r == CW'(PW - 1)) begin
          dn_nxt = dv_quo;
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_r || out_tready) begin
          on_nxt = fx_sgn[RES_NUM_W-1:0];
          od_nxt = fx_den[RES_DEN_W-1:0];
          oo_nxt = ord_r;
          og_nxt = neg_r;
          os_nxt = sts_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ms_r <= 2'd0;
      dc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ms_r <= ms_nxt;
      dc_r <= dc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    sg_r  <= sg_nxt;
    an_r  <= an_nxt;
    ad_r  <= ad_nxt;
    bn_r  <= bn_nxt;
    bd_r  <= bd_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    nm_r  <= nm_nxt;
    dn_r  <= dn_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    ord_r <= ord_nxt;
    sts_r <= sts_nxt;
    on_r  <= on_nxt;
    od_r  <= od_nxt;
    oo_r  <= oo_nxt;
    og_r  <= og_nxt;
    os_r  <= os_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = os_r;
  assign out_tdata  = OUT_TW'({og_r, oo_r, od_r, on_r});

  // an accepted item blocks the input until its result is staged
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after an accept");

  // GCD loop never sees a zero operand
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_GCD |-> x_r != '0 && y_r != '0)
    else $error("zero operand in GCD loop");

  // an error result carries a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> od_r == '0 && on_r == '0 && og_r == 1'b0)
    else $error("error result with nonzero fraction");

  // a loaded result appears only when the sequencer hands it over
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_DONE)
    else $error("output loaded outside hand-over");

endmodule

`default_nettype wire

>>> dv/fraction_arithmetic_unit_test.sv
// Testbench for fraction_arithmetic_unit: directed and random fraction requests,
// each result checked field by field against a built-in fraction predictor.
// Depends on fau_pkg and the fraction_arithmetic_unit RTL.
`timescale 1ns / 1ps

module fraction_arithmetic_unit_test;
  import fau_pkg::*;

  localparam int OPW        = 16;
  localparam int IN_TW      = ((4 * OPW + 7) / 8) * 8;
  localparam int IDLE_PCT   = 38;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_LEN   = 150;
  localparam int QUIET_MAX  = 4000;
  localparam int RAND_ITEMS = 800;
  localparam int BURST_LEN  = 150;
  localparam int OP_CODES   = 2 ** REQ_W;

  typedef logic signed [OPW-1:0] operand_t;

  typedef struct {
    logic signed [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0]        den;
    ord_t                        ord;
    logic                        neg;
    logic                        st;
  } frac_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic             out_tuser;

  frac_result_t pending_results[$];
  int  fails = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;
  int  op_seen[OP_CODES];
  int  err_seen = 0;
  int  quiet_cycles = 0;

  fraction_arithmetic_unit #(.OPERAND_WIDTH(OPW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Exact fraction arithmetic on 64-bit integers, reduced by Euclid's GCD.
  function automatic frac_result_t compute_fraction(op_t op, operand_t an, operand_t ad,
                                                    operand_t bn, operand_t bd);
    frac_result_t r;
    longint la, lad, lb, lbd, x, y, num, den, p, q, t, mag_n, mag_d;
    r.num = '0;
    r.den = '0;
    r.ord = ORD_LESS;
    r.neg = 1'b0;
    r.st  = ST_OK;
    la  = an;
    lad = ad;
    lb  = bn;
    lbd = bd;
    if (op > OP_CMP || ad == 0 || bd == 0) begin
      r.st = ST_ERR;
      return r;
    end
    if (op == OP_CMP) begin
      // bring both to positive denominators, then cross-multiply
      x = (lad < 0 ? -la : la) * (lbd < 0 ? -lbd : lbd);
      y = (lbd < 0 ? -lb : lb) * (lad < 0 ? -lad : lad);
      r.ord = (x < y) ? ORD_LESS : ((x == y) ? ORD_EQUAL : ORD_GREATER);
      return r;
    end
    case (op)
      OP_ADD: begin
        num = la * lbd + lad * lb;
        den = lad * lbd;
      end
      OP_SUB: begin
        num = la * lbd - lad * lb;
        den = lad * lbd;
      end
      OP_MUL: begin
        num = la * lb;
        den = lad * lbd;
      end
      default: begin
        num = la * lbd;
        den = lad * lb;
      end
    endcase
    if (den == 0) begin
      r.st = ST_ERR;
      return r;
    end
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    p = mag_n;
    q = mag_d;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    r.neg = (num != 0) && ((num < 0) != (den < 0));
    r.num = RES_NUM_W'(r.neg ? -(mag_n / p) : (mag_n / p));
    r.den = RES_DEN_W'(mag_d / p);
    return r;
  endfunction

  function automatic operand_t rand_operand();
    operand_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = '0;
          3: v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
      1, 2, 3: v = operand_t'(int'($urandom_range(0, 16)) - 8);
      // products of small factors give results that reduce a lot
      4, 5: begin
        v = operand_t'($urandom_range(1, 181) * $urandom_range(1, 181));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = operand_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic op_t rand_op();
    if ($urandom_range(0, 19) == 0)
      return op_t'($urandom_range(int'(OP_CMP) + 1, OP_CODES - 1));
    return op_t'($urandom_range(int'(OP_ADD), int'(OP_CMP)));
  endfunction

  // Offer one item, hold it until taken, then queue its predicted result.
  task automatic send_item(op_t op, operand_t an, operand_t ad, operand_t bn, operand_t bd);
    frac_result_t want;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bd, bn, ad, an};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    want = compute_fraction(op, an, ad, bn, bd);
    pending_results.push_back(want);
    op_seen[op]++;
    if (want.st == ST_ERR) err_seen++;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_item(rand_op(), rand_operand(), rand_operand(), rand_operand(), rand_operand());
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_ADD, 1, 2, 1, 3);
    send_item(OP_SUB, 1, 2, 1, 2);
    send_item(OP_MUL, -3, 4, 2, -9);
    send_item(OP_DIV, 2, 3, -4, 9);
    send_item(OP_CMP, 1, -2, -1, 2);
    send_item(OP_CMP, -1, 3, 1, 4);
    send_item(OP_CMP, 5, 7, 2, 3);
    // zero denominators on either input
    send_item(OP_ADD, 3, 0, 1, 2);
    send_item(OP_SUB, 3, 5, 1, 0);
    send_item(OP_CMP, 0, 0, 0, 7);
    send_item(OP_MUL, 0, 0, 0, 0);
    // division by a zero fraction
    send_item(OP_DIV, 7, 3, 0, -5);
    send_item(OP_MUL, 0, 5, 3, 7);
    send_item(OP_ADD, -1, -1, 0, -1);
    for (int k = int'(OP_CMP) + 1; k < OP_CODES; k++)
      send_item(op_t'(k), 1, 2, 3, 4);
    send_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_MUL, 16'h8000, 1, 16'h8000, 1);
    send_item(OP_DIV, 16'h8000, 1, 1, 16'h8000);
    send_item(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_item(OP_SUB, 16'h7fff, 1, 16'h8000, 1);
    send_item(OP_CMP, 16'h8000, 1, 16'h7fff, 1);
    send_item(OP_CMP, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(OP_DIV, 16'h8000, 16'h8000, -1, -1);
    wait_drain();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RAND_ITEMS / 100; i++) begin
      send_random(100);
      if ($urandom_range(0, 2) == 0) wait_drain();
    end
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_random(BURST_LEN);
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    stall_left = HOLD_LEN;
    send_random(12);
    wait_drain();
  endtask

  // Receiver: random stalls, plus a long hold-off counted down here.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frac_result_t want;
    logic signed [RES_NUM_W-1:0] got_num;
    if (rst_n && out_tvalid && out_tready) begin
      got_num = out_tdata[RES_NUM_W-1:0];
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("res_num", want.num, got_num);
        check_field("res_den", want.den, out_tdata[RES_NUM_W +: RES_DEN_W]);
        check_field("order", want.ord, out_tdata[RES_NUM_W + RES_DEN_W +: ORD_W]);
        check_field("is_negative", want.neg, out_tdata[RES_NUM_W + RES_DEN_W + ORD_W]);
        check_field("status", want.st, out_tuser);
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  initial begin
    while (quiet_cycles < QUIET_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_back_to_back();
    test_output_hold();
    wait_drain();
    repeat (TAIL_LEN) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fails++;
    end
    $display("Requests sent: %0d add, %0d sub, %0d mul, %0d div, %0d compare, %0d bad opcode",
             op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL], op_seen[OP_DIV],
             op_seen[OP_CMP], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("%0d of them ended with error status; %0d mismatches seen", err_seen, fails);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
